[src/spsg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package spsg_pkg;

	// Window limit
	localparam int unsigned LAST_SAMPLE_INDEX_DEF = 250;
	localparam int unsigned IDX_CMP_W = 12;

	// Q18 fixed point
	localparam int unsigned ACC_W = 19;
	localparam logic [ACC_W-1:0] Q18_ONE = 19'd262144;
	localparam logic [17:0] Q18_HALF = 18'd131072;
	localparam int unsigned EXP_BITS = 23;

	// Exponent scaling: fast x
	localparam logic [29:0] FAST_X_MUL = 30'd604905376;
	localparam logic [15:0] FAST_X_RND = 16'd32768;
	// Exponent scaling: slow x, (a*16384 + 62) / 125
	localparam logic [5:0] SLOW_X_ADD = 6'd62;
	localparam logic [6:0] SLOW_X_DIV = 7'd125;
	localparam logic [22:0] SLOW_X_MUL = 23'd4294967;
	// Exponent scaling: fast y
	localparam logic [27:0] FAST_Y_MUL = 28'd148561780;
	localparam logic [31:0] FAST_Y_RND = 32'h8000_0000;
	// Exponent scaling: slow y, (a^4 + 3750) / 7500 taken as (../4) / 1875
	localparam logic [11:0] SLOW_Y_ADD = 12'd3750;
	localparam logic [10:0] SLOW_Y_DIV = 11'd1875;
	localparam logic [23:0] SLOW_Y_MUL = 24'd9162596;

	localparam logic [24:0] OUT_MAX = 25'h1FF_FFFF;

	// Exponential lanes
	localparam int unsigned EXP_LANES = 4;
	localparam int unsigned LANE_XF = 0;
	localparam int unsigned LANE_YF = 1;
	localparam int unsigned LANE_XS = 2;
	localparam int unsigned LANE_YS = 3;

	typedef struct packed {
		logic [7:0]  sample_index;
		logic [23:0] fast_amplitude;
		logic [23:0] slow_amplitude;
		logic [13:0] start_phase;
	} spsg_in_t;

	typedef struct packed {
		logic [24:0] sample_value;
		logic        clipped;
	} spsg_out_t;

	typedef struct packed {
		logic                zero;
		logic [EXP_BITS-1:0] v;
	} spsg_exparg_t;

	typedef spsg_exparg_t [EXP_LANES-1:0] spsg_args_t;

	typedef logic [EXP_LANES-1:0][ACC_W-1:0] spsg_exps_t;

	typedef struct packed {
		logic        active;
		logic [23:0] amp_f;
		logic [23:0] amp_s;
	} spsg_side_t;

	// round(2^18 * exp(-2^(b-18)))
	function automatic logic [17:0] neg_exp_tab(input int b);
		logic [17:0] t;
		unique case (b)
			0: t = 18'd262143;
			1: t = 18'd262142;
			2: t = 18'd262140;
			3: t = 18'd262136;
			4: t = 18'd262128;
			5: t = 18'd262112;
			6: t = 18'd262080;
			7: t = 18'd262016;
			8: t = 18'd261888;
			9: t = 18'd261632;
			10: t = 18'd261122;
			11: t = 18'd260104;
			12: t = 18'd258080;
			13: t = 18'd254079;
			14: t = 18'd246261;
			15: t = 18'd231341;
			16: t = 18'd204158;
			17: t = 18'd158998;
			18: t = 18'd96437;
			19: t = 18'd35477;
			20: t = 18'd4801;
			21: t = 18'd88;
			default: t = 18'd0;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

[src/spsg_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module spsg_front import spsg_pkg::*; #(
	parameter int unsigned LAST_SAMPLE_INDEX = LAST_SAMPLE_INDEX_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_ready,
	input  wire spsg_in_t   item,
	output logic            args_valid,
	input  wire logic       args_ready,
	output spsg_args_t      args,
	output spsg_side_t      side
);

	localparam int unsigned NS = 6;

	logic [NS-1:0] vld_s;
	logic [NS-1:0] vld_in;
	logic [NS:0]   go;

	// Stage registers
	spsg_side_t  side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	logic [13:0] a_s1;
	logic [27:0] xf_s2, xf_s3, xf_s4, xf_s5;
	logic [27:0] n_s2;
	logic [21:0] xs0_s2;
	logic [21:0] xs_s3, xs_s4, xs_s5;
	logic [17:0] a2_s2;
	logic        bigf_s2, bigf_s3, bigf_s4, bigf_s5;
	logic        bigs_s2, bigs_s3, bigs_s4, bigs_s5;
	logic [35:0] p_s3;
	logic [23:0] yf_s4, yf_s5;
	logic [33:0] r4_s4, r4_s5;
	logic [40:0] lo_s4, hi_s4;
	logic [23:0] q0_s5;
	spsg_args_t  args_s6;

	// Combinational terms
	logic [14:0] diff;
	logic        idx_ok;
	logic [43:0] xf_prod;
	logic [27:0] n_c;
	logic [50:0] xs_prod;
	logic [17:0] a2_c;
	logic [27:0] xs_rem;
	logic [21:0] xs_c;
	logic [35:0] p_c;
	logic [55:0] yf_prod;
	logic [35:0] r_c;
	logic [33:0] r4_c;
	logic [40:0] lo_c, hi_c;
	logic [57:0] q_sum;
	logic [33:0] ys_rem;
	logic [23:0] ys_c;
	spsg_args_t  args_c;

	// Stall chain: a stage takes new data when empty or when it moves on
	always_comb begin
		go[NS] = args_ready;
		for (int k = NS - 1; k >= 0; k--) begin
			go[k] = ~vld_s[k] | go[k + 1];
		end
	end

	assign item_ready = go[0];
	assign args_valid = vld_s[NS-1];
	assign args       = args_s6;
	assign side       = side_s6;

	// Valid bit that each stage takes when it advances
	assign vld_in = {vld_s[NS-2:0], item_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (go[k]) begin
					vld_s[k] <= vld_in[k];
				end
			end
		end
	end

	// Stage 1: time offset and window check
	always_comb begin
		diff   = {1'b0, item.sample_index, 6'b0} - {1'b0, item.start_phase};
		idx_ok = {4'b0, item.sample_index} <= IDX_CMP_W'(LAST_SAMPLE_INDEX);
	end

	// Stage 2: linear exponents and square
	always_comb begin
		xf_prod = 44'(a_s1) * 44'(FAST_X_MUL) + 44'(FAST_X_RND);
		n_c     = {a_s1, 14'b0} + 28'(SLOW_X_ADD);
		xs_prod = 51'(n_c) * 51'(SLOW_X_MUL);
		a2_c    = 18'(a_s1[8:0]) * 18'(a_s1[8:0]);
	end

	// Stage 3: correct slow x quotient, fourth power
	always_comb begin
		xs_rem = n_s2 - 28'(xs0_s2) * 28'(SLOW_X_DIV);
		xs_c   = (xs_rem >= 28'(SLOW_X_DIV)) ? xs0_s2 + 22'd1 : xs0_s2;
		p_c    = 36'(a2_s2) * 36'(a2_s2);
	end

	// Stage 4: fast y, partial products of slow y quotient
	always_comb begin
		yf_prod = 56'(p_s3[27:0]) * 56'(FAST_Y_MUL) + 56'(FAST_Y_RND);
		r_c     = p_s3 + 36'(SLOW_Y_ADD);
		r4_c    = r_c[35:2];
		lo_c    = 41'(r4_c[16:0]) * 41'(SLOW_Y_MUL);
		hi_c    = 41'(r4_c[33:17]) * 41'(SLOW_Y_MUL);
	end

	// Stage 5: combine partial products
	assign q_sum = (58'(hi_s4) << 17) + 58'(lo_s4);

	// Stage 6: correct slow y quotient, form exponent arguments
	always_comb begin
		ys_rem = r4_s5 - 34'(q0_s5) * 34'(SLOW_Y_DIV);
		ys_c   = (ys_rem >= 34'(SLOW_Y_DIV)) ? q0_s5 + 24'd1 : q0_s5;
		args_c[LANE_XF].zero = |xf_s5[27:23];
		args_c[LANE_XF].v    = xf_s5[22:0];
		args_c[LANE_YF].zero = bigf_s5 | yf_s5[23];
		args_c[LANE_YF].v    = yf_s5[22:0];
		args_c[LANE_XS].zero = 1'b0;
		args_c[LANE_XS].v    = {1'b0, xs_s5};
		args_c[LANE_YS].zero = bigs_s5 | ys_c[23];
		args_c[LANE_YS].v    = ys_c[22:0];
	end

	always_ff @(posedge clk) begin
		if (go[0]) begin
			side_s1.active <= idx_ok & ~diff[14];
			side_s1.amp_f  <= item.fast_amplitude;
			side_s1.amp_s  <= item.slow_amplitude;
			a_s1           <= diff[13:0];
		end
		if (go[1]) begin
			side_s2 <= side_s1;
			xf_s2   <= xf_prod[43:16];
			n_s2    <= n_c;
			xs0_s2  <= xs_prod[50:29];
			a2_s2   <= a2_c;
			bigf_s2 <= |a_s1[13:7];
			bigs_s2 <= |a_s1[13:9];
		end
		if (go[2]) begin
			side_s3 <= side_s2;
			xf_s3   <= xf_s2;
			xs_s3   <= xs_c;
			p_s3    <= p_c;
			bigf_s3 <= bigf_s2;
			bigs_s3 <= bigs_s2;
		end
		if (go[3]) begin
			side_s4 <= side_s3;
			xf_s4   <= xf_s3;
			xs_s4   <= xs_s3;
			yf_s4   <= yf_prod[55:32];
			r4_s4   <= r4_c;
			lo_s4   <= lo_c;
			hi_s4   <= hi_c;
			bigf_s4 <= bigf_s3;
			bigs_s4 <= bigs_s3;
		end
		if (go[4]) begin
			side_s5 <= side_s4;
			xf_s5   <= xf_s4;
			xs_s5   <= xs_s4;
			yf_s5   <= yf_s4;
			r4_s5   <= r4_s4;
			q0_s5   <= q_sum[57:34];
			bigf_s5 <= bigf_s4;
			bigs_s5 <= bigs_s4;
		end
		if (go[5]) begin
			side_s6 <= side_s5;
			args_s6 <= args_c;
		end
	end

endmodule

`default_nettype wire

[src/spsg_exp_pipe.sv]
`timescale 1ns / 1ps
`default_nettype none

module spsg_exp_pipe import spsg_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       args_valid,
	output logic            args_ready,
	input  wire spsg_args_t args,
	input  wire spsg_side_t side_in,
	output logic            exps_valid,
	input  wire logic       exps_ready,
	output spsg_exps_t      exps,
	output spsg_side_t      side_out
);

	localparam int unsigned NS = EXP_BITS;

	logic [NS-1:0] vld_s;
	logic [NS-1:0] vld_in;
	logic [NS:0]   go;

	// One rounded table multiply per stage and lane
	spsg_args_t arg_s  [NS];
	spsg_exps_t acc_s  [NS];
	spsg_side_t side_s [NS];

	spsg_args_t src_arg [NS];
	spsg_exps_t src_acc [NS];
	spsg_side_t src_side[NS];
	spsg_exps_t nxt_acc [NS];

	always_comb begin
		go[NS] = exps_ready;
		for (int k = NS - 1; k >= 0; k--) begin
			go[k] = ~vld_s[k] | go[k + 1];
		end
	end

	assign args_ready = go[0];
	assign exps_valid = vld_s[NS-1];
	assign side_out   = side_s[NS-1];

	// Select stage sources
	always_comb begin
		src_arg[0]  = args;
		src_side[0] = side_in;
		for (int l = 0; l < EXP_LANES; l++) begin
			src_acc[0][l] = Q18_ONE;
		end
		for (int k = 1; k < NS; k++) begin
			src_arg[k]  = arg_s[k - 1];
			src_side[k] = side_s[k - 1];
			src_acc[k]  = acc_s[k - 1];
		end
	end

	// Apply bit k of each exponent
	always_comb begin
		logic [36:0] prod;
		for (int k = 0; k < NS; k++) begin
			for (int l = 0; l < EXP_LANES; l++) begin
				prod = 37'(src_acc[k][l]) * 37'(neg_exp_tab(k)) + 37'(Q18_HALF);
				nxt_acc[k][l] = src_arg[k][l].v[k] ? prod[36:18] : src_acc[k][l];
			end
		end
	end

	// Zero the lanes whose exponent is out of range
	always_comb begin
		for (int l = 0; l < EXP_LANES; l++) begin
			exps[l] = arg_s[NS-1][l].zero ? '0 : acc_s[NS-1][l];
		end
	end

	// Valid bit that each stage takes when it advances
	assign vld_in = {vld_s[NS-2:0], args_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (go[k]) begin
					vld_s[k] <= vld_in[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NS; k++) begin
			if (go[k]) begin
				arg_s[k]  <= src_arg[k];
				side_s[k] <= src_side[k];
				acc_s[k]  <= nxt_acc[k];
			end
		end
	end

endmodule

`default_nettype wire

[src/spsg_mix.sv]
`timescale 1ns / 1ps
`default_nettype none

module spsg_mix import spsg_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       exps_valid,
	output logic            exps_ready,
	input  wire spsg_exps_t exps,
	input  wire spsg_side_t side,
	output logic            sample_valid,
	input  wire logic       sample_ready,
	output spsg_out_t       sample
);

	localparam int unsigned NS = 3;

	logic [NS-1:0] vld_s;
	logic [NS-1:0] vld_in;
	logic [NS:0]   go;

	spsg_side_t       side_s1, side_s2;
	logic [ACC_W-1:0] shp_f_s1, shp_s_s1;
	logic [42:0]      pf_s2, ps_s2;
	spsg_out_t        out_s3;

	logic [37:0] shf_prod, shs_prod;
	logic [43:0] sum_full;
	logic [25:0] sum_c;
	spsg_out_t   out_c;

	always_comb begin
		go[NS] = sample_ready;
		for (int k = NS - 1; k >= 0; k--) begin
			go[k] = ~vld_s[k] | go[k + 1];
		end
	end

	assign exps_ready   = go[0];
	assign sample_valid = vld_s[NS-1];
	assign sample       = out_s3;

	// Shape factors
	always_comb begin
		shf_prod = 38'(exps[LANE_XF]) * 38'(Q18_ONE - exps[LANE_YF]) + 38'(Q18_HALF);
		shs_prod = 38'(exps[LANE_XS]) * 38'(Q18_ONE - exps[LANE_YS]) + 38'(Q18_HALF);
	end

	// Sum, truncate, saturate; zero the output of an inactive item
	always_comb begin
		sum_full = 44'(pf_s2) + 44'(ps_s2);
		sum_c    = sum_full[43:18];
		if (!side_s2.active) begin
			out_c.sample_value = '0;
			out_c.clipped      = 1'b0;
		end else if (sum_c > 26'(OUT_MAX)) begin
			out_c.sample_value = OUT_MAX;
			out_c.clipped      = 1'b1;
		end else begin
			out_c.sample_value = sum_c[24:0];
			out_c.clipped      = 1'b0;
		end
	end

	// Valid bit that each stage takes when it advances
	assign vld_in = {vld_s[NS-2:0], exps_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (go[k]) begin
					vld_s[k] <= vld_in[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go[0]) begin
			side_s1  <= side;
			shp_f_s1 <= shf_prod[36:18];
			shp_s_s1 <= shs_prod[36:18];
		end
		if (go[1]) begin
			side_s2 <= side_s1;
			pf_s2   <= 43'(side_s1.amp_f) * 43'(shp_f_s1);
			ps_s2   <= 43'(side_s1.amp_s) * 43'(shp_s_s1);
		end
		if (go[2]) begin
			out_s3 <= out_c;
		end
	end

endmodule

`default_nettype wire

[src/scintillator_pulse_sample_generator_unit.sv]
// Pipeline: the front stages, then the exponential chain, then the mix stages, from item accept to result valid.
// Throughput: one item per cycle while sample_ready is high; every stage is a register with its own valid bit,
// and a stage refills in the cycle it hands on, so stalls only hold the items.
// The exponential chain of 23 rounded table multiplies per lane sets the depth.
// Reset clears the valid bits only; the block takes items from the first cycle after.
`timescale 1ns / 1ps
`default_nettype none

module scintillator_pulse_sample_generator_unit import spsg_pkg::*; #(
	parameter int unsigned LAST_SAMPLE_INDEX = LAST_SAMPLE_INDEX_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     item_valid,
	output logic          item_ready,
	input  wire spsg_in_t item,
	output logic          sample_valid,
	input  wire logic     sample_ready,
	output spsg_out_t     sample
);

	logic       args_valid, args_ready;
	spsg_args_t args;
	spsg_side_t side_f;
	logic       exps_valid, exps_ready;
	spsg_exps_t exps;
	spsg_side_t side_e;

	// Offset, exponents
	spsg_front #(
		.LAST_SAMPLE_INDEX(LAST_SAMPLE_INDEX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.args_valid (args_valid),
		.args_ready (args_ready),
		.args       (args),
		.side       (side_f)
	);

	// Exponentials
	spsg_exp_pipe u_exp (
		.clk        (clk),
		.arst_n     (arst_n),
		.args_valid (args_valid),
		.args_ready (args_ready),
		.args       (args),
		.side_in    (side_f),
		.exps_valid (exps_valid),
		.exps_ready (exps_ready),
		.exps       (exps),
		.side_out   (side_e)
	);

	// Shapes, amplitudes, sum
	spsg_mix u_mix (
		.clk          (clk),
		.arst_n       (arst_n),
		.exps_valid   (exps_valid),
		.exps_ready   (exps_ready),
		.exps         (exps),
		.side         (side_e),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample)
	);

endmodule

`default_nettype wire
